// File: src/naive_pattern_matcher_macros.svh
// assertion macros for the naive pattern matcher
// used by the top level only; expects clk and rst_n in scope
`ifndef NAIVE_PATTERN_MATCHER_MACROS_SVH
`define NAIVE_PATTERN_MATCHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define NPM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npm assertion failed");

// next-cycle implication
`define NPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("npm assertion failed");

`else

`define NPM_ASSERT_SAME(lbl, ante, cons)
`define NPM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: src/npm_pkg.sv
// shared constants, codes and control structs of the naive pattern matcher
// no dependencies
`default_nettype none

package npm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int PLEN_W      = $clog2(MAX_PATTERN + 1);
  localparam int MAX_TEXT    = 65535;
  localparam int POS_W       = $clog2(MAX_TEXT + 1);
  localparam int SHIFT_W     = 16;
  localparam int BYTE_W      = 8;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2,
    CMD_END     = 2'd3
  } npm_cmd_code_t;

  typedef enum logic {
    KIND_MATCH = 1'b0,
    KIND_DONE  = 1'b1
  } npm_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } npm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic push;
    logic set_ovf;
    logic finish;
    logic eval;
  } npm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_full;
    logic pattern_full;
    logic text_full;
  } npm_status_t;

endpackage

`default_nettype wire

// File: src/npm_ctrl.sv
// controller of the naive pattern matcher: input handshake and command decode
// depends on npm_pkg
`default_nettype none

module npm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_command,
  input  wire logic                out_stall,
  input  wire npm_pkg::npm_status_t sts,
  output logic                     in_stall,
  output npm_pkg::npm_cmd_t        cmd
);

  npm_pkg::npm_state_t state_r, state_nxt;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    cmd         = '0;
    accept      = 1'b0;
    unique case (state_r)
      npm_pkg::ST_IDLE: begin
        // output slot must be free or draining this cycle
        in_stall = sts.out_full && out_stall;
        accept   = in_valid && !in_stall;
        unique case (in_command)
          npm_pkg::CMD_CLEAR: begin
            cmd.clear = accept;
          end
          npm_pkg::CMD_PATTERN: begin
            cmd.append  = accept && !sts.pattern_full;
            cmd.set_ovf = accept && sts.pattern_full;
          end
          npm_pkg::CMD_TEXT: begin
            cmd.push    = accept && !sts.text_full;
            cmd.set_ovf = accept && sts.text_full;
            if (accept && !sts.text_full) begin
              state_nxt = npm_pkg::ST_EVAL;
            end
          end
          npm_pkg::CMD_END: begin
            cmd.finish = accept;
          end
          default: begin
            cmd = '0;
          end
        endcase
      end
      npm_pkg::ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = npm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = npm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/npm_dp.sv
// datapath of the naive pattern matcher: pattern and window shift lines,
// parallel byte compare cells, counters and the output register; uses npm_pkg
`default_nettype none

module npm_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire npm_pkg::npm_cmd_t             cmd,
  input  wire logic [npm_pkg::BYTE_W-1:0]    in_data_byte,
  input  wire logic                          out_stall,
  output npm_pkg::npm_status_t               sts,
  output logic                               out_valid,
  output logic                               out_kind,
  output logic [npm_pkg::SHIFT_W-1:0]        out_shift,
  output logic                               out_matched,
  output logic                               out_found_any,
  output logic                               out_overflow
);

  // pattern held newest-first so cell k compares window[k] with pat[k]
  logic [npm_pkg::BYTE_W-1:0]  pat_r [npm_pkg::MAX_PATTERN];
  logic [npm_pkg::BYTE_W-1:0]  win_r [npm_pkg::MAX_PATTERN];
  logic [npm_pkg::PLEN_W-1:0]  len_r;
  logic [npm_pkg::POS_W-1:0]   pos_r;
  logic                        found_r;
  logic                        ovf_r;

  logic                        valid_r, valid_nxt;
  logic                        kind_r;
  logic [npm_pkg::SHIFT_W-1:0] shift_r;
  logic                        matched_r;
  logic                        found_out_r;
  logic                        ovf_out_r;

  logic [npm_pkg::MAX_PATTERN-1:0] cell_ok;
  logic                            len_zero;
  logic                            hit;
  logic [npm_pkg::POS_W-1:0]       hit_shift;
  logic                            load_match;

  always_comb begin
    for (int k = 0; k < npm_pkg::MAX_PATTERN; k++) begin
      cell_ok[k] = (npm_pkg::PLEN_W'(k) >= len_r) || (win_r[k] == pat_r[k]);
    end
  end

  assign len_zero   = (len_r == '0);
  assign hit        = len_zero ||
                      ((pos_r >= npm_pkg::POS_W'(len_r)) && (&cell_ok));
  assign hit_shift  = len_zero ? (pos_r - npm_pkg::POS_W'(1))
                               : (pos_r - npm_pkg::POS_W'(len_r));
  assign load_match = cmd.eval && hit;

  assign sts.out_full     = valid_r;
  assign sts.pattern_full = (len_r == npm_pkg::PLEN_W'(npm_pkg::MAX_PATTERN));
  assign sts.text_full    = (pos_r == npm_pkg::POS_W'(npm_pkg::MAX_TEXT));

  always_comb begin
    if (load_match || cmd.finish) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  // shift lines
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      pat_r[0] <= in_data_byte;
      for (int k = 1; k < npm_pkg::MAX_PATTERN; k++) begin
        pat_r[k] <= pat_r[k-1];
      end
    end
    if (cmd.push) begin
      win_r[0] <= in_data_byte;
      for (int k = 1; k < npm_pkg::MAX_PATTERN; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  // counters and flags
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      len_r   <= '0;
      pos_r   <= '0;
      found_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.append) begin
        len_r <= len_r + npm_pkg::PLEN_W'(1);
      end
      if (cmd.set_ovf) begin
        ovf_r <= 1'b1;
      end
      if (cmd.push) begin
        pos_r <= pos_r + npm_pkg::POS_W'(1);
      end
      if (load_match) begin
        found_r <= 1'b1;
      end
      if (cmd.finish) begin
        pos_r   <= '0;
        found_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_match) begin
      kind_r      <= npm_pkg::KIND_MATCH;
      shift_r     <= npm_pkg::SHIFT_W'(hit_shift);
      matched_r   <= 1'b1;
      found_out_r <= 1'b1;
      ovf_out_r   <= ovf_r;
    end else if (cmd.finish) begin
      kind_r      <= npm_pkg::KIND_DONE;
      shift_r     <= npm_pkg::SHIFT_W'(pos_r);
      matched_r   <= len_zero;
      found_out_r <= found_r || len_zero;
      ovf_out_r   <= ovf_r;
    end
  end

  assign out_valid     = valid_r;
  assign out_kind      = kind_r;
  assign out_shift     = shift_r;
  assign out_matched   = matched_r;
  assign out_found_any = found_out_r;
  assign out_overflow  = ovf_out_r;

endmodule

`default_nettype wire

// File: src/naive_pattern_matcher.sv
// naive_pattern_matcher: streaming exact byte-pattern search, top level
// instantiates npm_ctrl and npm_dp; uses npm_pkg and the assertion macros
//
// usage
//   input items: in_command with in_data_byte, valid/stall handshake; an item
//     is taken at a clock edge with in_valid high and in_stall low
//   commands: clear (drops pattern, text state and overflow), append pattern
//     byte, text byte, end of text
//   result items on out_*: a match report (kind 0) carrying the shift of the
//     window that matches, or a done report (kind 1) carrying the text length
//   a text byte is handled in steps: the accept cycle shifts it into the
//     window, the next cycle runs all 32 byte-compare cells and loads the
//     output register on a match; clear, append and end of text need only
//     the accept cycle; a match report is registered at the end of its
//     compare cycle, a done report by the edge that takes end of text
//   no new item is taken during the compare cycle of a text byte
//   reset (rst_n low, synchronous) empties the pattern, the text counters,
//     the overflow flag and the output register
//   a result held under out_stall blocks further input until it is taken;
//     the output register drains while the next item is accepted
`default_nettype none
`include "naive_pattern_matcher_macros.svh"

module naive_pattern_matcher (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_command,
  input  wire logic [npm_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_kind,
  output logic [npm_pkg::SHIFT_W-1:0]      out_shift,
  output logic                             out_matched,
  output logic                             out_found_any,
  output logic                             out_overflow
);

  // command and status between controller and datapath
  npm_pkg::npm_cmd_t    cmd;
  npm_pkg::npm_status_t sts;

  // controller: handshake, decode, compare-cycle sequencing
  npm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .out_stall  (out_stall),
    .sts        (sts),
    .in_stall   (in_stall),
    .cmd        (cmd)
  );

  // datapath: shift lines, compare cells, counters, output register
  npm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_data_byte  (in_data_byte),
    .out_stall     (out_stall),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_shift     (out_shift),
    .out_matched   (out_matched),
    .out_found_any (out_found_any),
    .out_overflow  (out_overflow)
  );

  // a held, stalled result must block new input
  `NPM_ASSERT_SAME(a_hold_blocks_input, out_valid && out_stall, in_stall)

  // the compare cycle after a text byte takes no new item
  `NPM_ASSERT_NEXT(a_eval_blocks_input, cmd.push, in_stall)

  // end of text always produces a done report next cycle
  `NPM_ASSERT_NEXT(a_finish_reports, cmd.finish,
                   out_valid && (out_kind == npm_pkg::KIND_DONE))

  // match reports always carry matched and found_any
  `NPM_ASSERT_SAME(a_match_flags, out_valid && (out_kind == npm_pkg::KIND_MATCH),
                   out_matched && out_found_any)

endmodule

`default_nettype wire
